FILE: rtl/sprh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sprh_pkg;

   localparam int CAPACITY_DEF = 1024;

   // field widths
   localparam int SEQ_W    = 16;
   localparam int HANDLE_W = 32;
   localparam int TIME_W   = 32;
   localparam int COUNT_W  = 8;
   localparam int STAT_W   = 3;
   localparam int HOLD_W   = 20;
   localparam int CULL_W   = 24;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 40;

   // register indexes
   localparam logic [2:0] REG_RTT_MS     = 3'd0;
   localparam logic [2:0] REG_RTT_MULT   = 3'd1;
   localparam logic [2:0] REG_MIN_HOLD   = 3'd2;
   localparam logic [2:0] REG_CULL_FACT  = 3'd3;
   localparam logic [2:0] REG_MAX_ENTRY  = 3'd4;

   // commands
   localparam logic CMD_RECORD = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_STORED     = 3'd0;
   localparam logic [STAT_W-1:0] STAT_STORED_DUP = 3'd1;
   localparam logic [STAT_W-1:0] STAT_HIT        = 3'd2;
   localparam logic [STAT_W-1:0] STAT_MISS       = 3'd3;
   localparam logic [STAT_W-1:0] STAT_TOO_SOON   = 3'd4;
   localparam logic [STAT_W-1:0] STAT_DROPPED    = 3'd5;

   // one history slot as stored in memory
   typedef struct packed {
      logic                valid;
      logic [COUNT_W-1:0]  retx;
      logic [TIME_W-1:0]   send_time;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

endpackage
`default_nettype wire

FILE: rtl/sent_packet_retransmit_history_top.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | handshake           | payload
// req     | in  | req_tvalid/tready   | tuser command, tdata seq/handle/now
// rsp     | out | rsp_tvalid/tready   | tuser status, tdata handle/count
// csr     | in  | csr_we              | csr_addr index, csr_wdata value
// One item at a time. A query reads its slot only when the sequence number
// lies inside the window; a record first runs the cull walk from the oldest
// slot, reads its slot for a duplicate when inside the window, and on removing
// the oldest runs a trim walk; the walk is paced by the registered read.
// After reset a clearing pass writes every slot, with
// req_tready low. A result waits in the output register while rsp_tready
// is low; the next item is taken but its result waits behind it.
module sent_packet_retransmit_history_top
   import sprh_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic                  req_tuser,   // command
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // seq_num, packet_handle, now_ms
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [STAT_W-1:0]          rsp_tuser,   // status
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // found_handle, retransmit_count
   input  wire logic                  csr_we,
   input  wire logic [2:0]            csr_addr,
   input  wire logic [15:0]           csr_wdata
);

   localparam int AW = $clog2(CAPACITY);

   logic [15:0] rtt_ff;
   logic [3:0]  mult_ff;
   logic [15:0] min_hold_ff;
   logic [3:0]  cull_fact_ff;
   logic [10:0] max_entry_ff;

   logic [HOLD_W-1:0] hold;
   logic [CULL_W-1:0] cull_hold;
   logic              mem_rd_en, mem_wr_en;
   logic [AW-1:0]     mem_rd_addr, mem_wr_addr;
   entry_type         mem_rd_data, mem_wr_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rtt_ff       <= 16'd0;
         mult_ff      <= 4'd3;
         min_hold_ff  <= 16'd1000;
         cull_fact_ff <= 4'd3;
         max_entry_ff <= 11'd1024;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_RTT_MS:    rtt_ff       <= csr_wdata;
            REG_RTT_MULT:  mult_ff      <= csr_wdata[3:0];
            REG_MIN_HOLD:  min_hold_ff  <= csr_wdata;
            REG_CULL_FACT: cull_fact_ff <= csr_wdata[3:0];
            REG_MAX_ENTRY: max_entry_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   sprh_hold u_hold (
      .clock          (clock),
      .rtt_ms         (rtt_ff),
      .rtt_multiplier (mult_ff),
      .min_hold_ms    (min_hold_ff),
      .cull_factor    (cull_fact_ff),
      .hold           (hold),
      .cull_hold      (cull_hold)
   );

   sprh_mem #(.CAPACITY(CAPACITY), .AW(AW)) u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   sprh_ctrl #(.CAPACITY(CAPACITY), .AW(AW)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .rtt_ms      (rtt_ff),
      .max_entries (max_entry_ff),
      .hold        (hold),
      .cull_hold   (cull_hold),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   // only a hit returns a handle and a count
   a_hit_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != STAT_HIT)) |-> (rsp_tdata == '0))
      else $error("non-hit result carries payload");

   // one item in flight: busy right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item taken while busy");

   // a new result appears only after an item was accepted
   a_result_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !req_tready || $past(!req_tready))
      else $error("result without an item");

endmodule
`default_nettype wire

FILE: rtl/sprh_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module sprh_mem
   import sprh_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int AW = $clog2(CAPACITY)
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output entry_type          rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire entry_type     wr_data
);

   entry_type mem [CAPACITY];

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: rtl/sprh_hold.sv
`timescale 1ns / 1ps
`default_nettype none
module sprh_hold
   import sprh_pkg::*;
(
   input  wire logic              clock,
   input  wire logic [15:0]       rtt_ms,
   input  wire logic [3:0]        rtt_multiplier,
   input  wire logic [15:0]       min_hold_ms,
   input  wire logic [3:0]        cull_factor,
   output logic [HOLD_W-1:0]      hold,
   output logic [CULL_W-1:0]      cull_hold
);

   logic [HOLD_W-1:0] raw;
   logic [HOLD_W-1:0] hold_ff, hold_in;
   logic [CULL_W-1:0] cull_ff, cull_in;

   // hold time is the larger of rtt times multiplier and the minimum
   always_comb begin
      raw     = HOLD_W'(rtt_multiplier) * HOLD_W'(rtt_ms);
      hold_in = (raw < HOLD_W'(min_hold_ms)) ? HOLD_W'(min_hold_ms) : raw;
      cull_in = CULL_W'(hold_ff) * CULL_W'(cull_factor);
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      cull_ff <= cull_in;
   end

   assign hold      = hold_ff;
   assign cull_hold = cull_ff;

endmodule
`default_nettype wire

FILE: rtl/sprh_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module sprh_ctrl
   import sprh_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int AW = $clog2(CAPACITY)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic                  req_tuser,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [STAT_W-1:0]          rsp_tuser,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic [15:0]           rtt_ms,
   input  wire logic [10:0]           max_entries,
   input  wire logic [HOLD_W-1:0]     hold,
   input  wire logic [CULL_W-1:0]     cull_hold,
   output logic                       mem_rd_en,
   output logic [AW-1:0]              mem_rd_addr,
   input  wire entry_type             mem_rd_data,
   output logic                       mem_wr_en,
   output logic [AW-1:0]              mem_wr_addr,
   output entry_type                  mem_wr_data
);

   localparam int SW = AW + 1;
   localparam int MW = 18;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_CULL_RD, ST_CULL_EV, ST_REC_RD, ST_REC_DUP,
      ST_INSERT, ST_QRY_RD, ST_QRY_EV, ST_RESP
   } state_type;

   state_type             state_ff, state_in;
   logic [AW-1:0]         clr_ff, clr_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [SEQ_W-1:0]      oldest_ff, oldest_in;
   logic [SW-1:0]         span_ff, span_in;
   logic [SEQ_W-1:0]      seq_ff, seq_in;
   logic [HANDLE_W-1:0]   handle_ff, handle_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic                  trim_ff, trim_in;
   logic [AW-1:0]         slot_ff, slot_in;
   logic [STAT_W-1:0]     status_ff, status_in;
   logic [HANDLE_W-1:0]   found_ff, found_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0]   rsp_handle_ff, rsp_handle_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic [SEQ_W-1:0] d;
   logic             ahead;
   logic [MW-1:0]    mag;
   logic             in_win;
   logic [MW-1:0]    sum_fwd;
   logic [AW-1:0]    slot_d;
   logic [MW-1:0]    sum_back;
   logic [AW-1:0]    slot_back;
   logic [AW-1:0]    head_next;
   logic [MW-1:0]    new_span;
   logic             drop;
   logic [TIME_W:0]  t_hold, t_cull, t_rtt;
   logic [COUNT_W-1:0] cnt_next;
   entry_type        e;

   // position of the item's sequence number relative to the oldest entry
   always_comb begin
      d        = seq_ff - oldest_ff;
      ahead    = (d < 16'h8000) || ((d == 16'h8000) && (seq_ff > oldest_ff));
      mag      = MW'(18'h10000 - MW'(d));
      in_win   = (span_ff != '0) && ahead && (MW'(d) < MW'(span_ff));
      sum_fwd  = MW'(head_ff) + MW'(d);
      if (sum_fwd >= MW'(CAPACITY)) begin
         sum_fwd = sum_fwd - MW'(CAPACITY);
      end
      slot_d   = AW'(sum_fwd);
      sum_back = MW'(head_ff) + MW'(CAPACITY) - mag;
      if (sum_back >= MW'(CAPACITY)) begin
         sum_back = sum_back - MW'(CAPACITY);
      end
      slot_back = AW'(sum_back);
      head_next = (head_ff == AW'(CAPACITY - 1)) ? '0 : head_ff + 1'b1;
   end

   // age tests on the entry just read, and its next retransmit count
   always_comb begin
      e      = mem_rd_data;
      t_hold = {1'b0, e.send_time} + (TIME_W+1)'(hold);
      t_cull = {1'b0, e.send_time} + (TIME_W+1)'(cull_hold);
      t_rtt  = {1'b0, e.send_time} + (TIME_W+1)'(rtt_ms);
      drop   = (MW'(span_ff) >= MW'(max_entries)) ||
               (!(t_hold > {1'b0, now_ff}) && (t_cull <= {1'b0, now_ff}));
      cnt_next = ((e.send_time != '0) && (e.retx != 8'hff)) ? e.retx + 1'b1 : e.retx;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      head_in       = head_ff;
      oldest_in     = oldest_ff;
      span_in       = span_ff;
      seq_in        = seq_ff;
      handle_in     = handle_ff;
      now_in        = now_ff;
      trim_in       = trim_ff;
      slot_in       = slot_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_count_in  = rsp_count_ff;
      new_span      = '0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = head_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = slot_ff;
      mem_wr_data   = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == AW'(CAPACITY - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               seq_in    = req_tdata[15:0];
               handle_in = req_tdata[47:16];
               now_in    = req_tdata[79:48];
               found_in  = '0;
               count_in  = '0;
               trim_in   = 1'b0;
               if (req_tuser == CMD_QUERY) begin
                  status_in = STAT_MISS;
                  state_in  = ST_QRY_RD;
               end else begin
                  status_in = STAT_STORED;
                  state_in  = ST_CULL_RD;
               end
            end
         end
         ST_CULL_RD: begin
            if (span_ff == '0) begin
               state_in = trim_ff ? ST_INSERT : ST_REC_RD;
            end else begin
               mem_rd_en = 1'b1;
               state_in  = ST_CULL_EV;
            end
         end
         ST_CULL_EV: begin
            if (!e.valid) begin
               head_in   = head_next;
               oldest_in = oldest_ff + 1'b1;
               span_in   = span_ff - 1'b1;
               state_in  = ST_CULL_RD;
            end else if (trim_ff) begin
               state_in = ST_INSERT;
            end else if (drop) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = head_ff;
               mem_wr_data = e;
               mem_wr_data.valid = 1'b0;
               head_in   = head_next;
               oldest_in = oldest_ff + 1'b1;
               span_in   = span_ff - 1'b1;
               state_in  = ST_CULL_RD;
            end else begin
               state_in = ST_REC_RD;
            end
         end
         ST_REC_RD: begin
            if (in_win) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = slot_d;
               slot_in     = slot_d;
               state_in    = ST_REC_DUP;
            end else begin
               state_in = ST_INSERT;
            end
         end
         ST_REC_DUP: begin
            state_in = ST_INSERT;
            if (e.valid) begin
               status_in   = STAT_STORED_DUP;
               mem_wr_en   = 1'b1;
               mem_wr_data = e;
               mem_wr_data.valid = 1'b0;
               // removing the oldest trims the empty slots behind it
               if (d == '0) begin
                  head_in   = head_next;
                  oldest_in = oldest_ff + 1'b1;
                  span_in   = span_ff - 1'b1;
                  trim_in   = 1'b1;
                  state_in  = ST_CULL_RD;
               end
            end
         end
         ST_INSERT: begin
            state_in = ST_RESP;
            mem_wr_data.valid     = 1'b1;
            mem_wr_data.retx      = '0;
            mem_wr_data.send_time = now_ff;
            mem_wr_data.handle    = handle_ff;
            if (span_ff == '0) begin
               oldest_in   = seq_ff;
               span_in     = SW'(1);
               mem_wr_en   = 1'b1;
               mem_wr_addr = head_ff;
            end else if (!ahead) begin
               new_span = MW'(span_ff) + mag;
               if (new_span > MW'(CAPACITY)) begin
                  status_in = STAT_DROPPED;
               end else begin
                  head_in     = slot_back;
                  oldest_in   = seq_ff;
                  span_in     = SW'(new_span);
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = slot_back;
               end
            end else if (MW'(d) >= MW'(span_ff)) begin
               new_span = MW'(d) + 1'b1;
               if (new_span > MW'(CAPACITY)) begin
                  status_in = STAT_DROPPED;
               end else begin
                  span_in     = SW'(new_span);
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = slot_d;
               end
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = slot_d;
            end
         end
         ST_QRY_RD: begin
            if (in_win) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = slot_d;
               slot_in     = slot_d;
               state_in    = ST_QRY_EV;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_QRY_EV: begin
            state_in = ST_RESP;
            if (e.valid) begin
               if ((e.send_time != '0) && (e.retx != '0) && ({1'b0, now_ff} < t_rtt)) begin
                  status_in = STAT_TOO_SOON;
               end else begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = e;
                  mem_wr_data.retx      = cnt_next;
                  mem_wr_data.send_time = now_ff;
                  status_in = STAT_HIT;
                  found_in  = e.handle;
                  count_in  = cnt_next;
               end
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_handle_in = found_ff;
               rsp_count_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         oldest_ff    <= '0;
         span_ff      <= '0;
         trim_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         oldest_ff    <= oldest_in;
         span_ff      <= span_in;
         trim_ff      <= trim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      seq_ff        <= seq_in;
      handle_ff     <= handle_in;
      now_ff        <= now_in;
      slot_ff       <= slot_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      count_ff      <= count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_handle_ff};

endmodule
`default_nettype wire
